/* hdl/qoi_pkg.sv */
// Shared types and constants for the QOI stream decoder.
package qoi_pkg;

	localparam int PIX_W = 29;

	typedef logic [PIX_W-1:0] pix_cnt_t;

	localparam logic [2:0] KIND_HEADER     = 3'd0;
	localparam logic [2:0] KIND_PIXEL      = 3'd1;
	localparam logic [2:0] KIND_BAD_MAGIC  = 3'd2;
	localparam logic [2:0] KIND_BAD_HEADER = 3'd3;
	localparam logic [2:0] KIND_TRUNC      = 3'd4;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_BODY   = 2'd1;
	localparam logic [1:0] PH_IGNORE = 2'd2;

	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_RGB  = 2'd1;
	localparam logic [1:0] OP_RGBA = 2'd2;
	localparam logic [1:0] OP_LUMA = 2'd3;

	localparam logic [1:0] MODE_HDR  = 2'd0;
	localparam logic [1:0] MODE_RGB  = 2'd1;
	localparam logic [1:0] MODE_RGBA = 2'd2;

	localparam logic [31:0] MAGIC_WORD = 32'h716f6966;
	localparam logic [3:0] HDR_MAGIC_END  = 4'd4;
	localparam logic [3:0] HDR_WIDTH_END  = 4'd8;
	localparam logic [3:0] HDR_HEIGHT_END = 4'd12;
	localparam logic [3:0] HDR_CH_BYTE    = 4'd13;
	localparam logic [3:0] HDR_END        = 4'd14;

	localparam logic [7:0] CHUNK_RGB  = 8'hfe;
	localparam logic [7:0] CHUNK_RGBA = 8'hff;
	localparam logic [1:0] TAG_INDEX  = 2'd0;
	localparam logic [1:0] TAG_DIFF   = 2'd1;
	localparam logic [1:0] TAG_LUMA   = 2'd2;
	localparam logic [1:0] TAG_RUN    = 2'd3;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic        alpha_valid;
		logic        last_item;
		logic [31:0] image_width;
		logic [31:0] image_height;
		logic [7:0]  header_channels;
		logic [7:0]  color_space;
	} item_t;

endpackage

/* hdl/qoi_ifs.sv */
// Stream, result and configuration channel interfaces.
interface qoi_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       stream_last;
	modport source (output valid, data_byte, stream_last, input ready);
	modport sink (input valid, data_byte, stream_last, output ready);
endinterface

interface qoi_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  item_kind;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic        alpha_valid;
	logic        last_item;
	logic [31:0] image_width;
	logic [31:0] image_height;
	logic [7:0]  header_channels;
	logic [7:0]  color_space;
	modport source (output valid, item_kind, red, green, blue, alpha, alpha_valid, last_item,
		image_width, image_height, header_channels, color_space, input ready);
	modport sink (input valid, item_kind, red, green, blue, alpha, alpha_valid, last_item,
		image_width, image_height, header_channels, color_space, output ready);
endinterface

interface qoi_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_channels_mode;
	modport source (output valid, out_channels_mode, input ready);
	modport sink (input valid, out_channels_mode, output ready);
endinterface

/* hdl/qoi_image_stream_decoder_unit.sv */
// QOI byte stream decoder: header check, chunk decode, hash index memory.
// Takes one file byte per cycle and gives one item per cycle unless a run, a truncation
// beat or back-pressure stalls it; a byte is registered in the input stage and its result
// in the output register. A run chunk holds the byte input while it gives its pixels beyond
// the first (up to 61), and a file that ends on its last header byte holds it for the
// truncation beat. The 64-entry color index is a synchronous memory read when a byte is
// taken and written when a pixel is decoded, with a bypass for same-cycle hits; per-entry
// valid bits make it read as zero after reset and every end of file without a clearing pass.
module qoi_image_stream_decoder_unit
	import qoi_pkg::*;
#(
	parameter int unsigned MAX_PIXELS = 400000000
) (
	input  logic         clk,
	input  logic         arst_n,
	qoi_byte_if.sink     stream,
	qoi_item_if.source   result,
	qoi_cfg_if.sink      cfg
);

	localparam logic [PIX_W-1:0] MAX_P = PIX_W'(MAX_PIXELS);

	logic [1:0] mode_q;
	logic s1_v_q, s1_last_q;
	logic [7:0] s1_byte_q;

	logic [1:0] phase_q, phase_n;
	logic [3:0] hcnt_q, hcnt_n;
	logic [31:0] hs_q, hs_n, wid_q, wid_n, hgt_q, hgt_n, pb_q, pb_n;
	logic four_q, four_n;
	pix_cnt_t pl_q, pl_n;
	logic [7:0] cr_q, cg_q, cb_q, ca_q, cr_n, cg_n, cb_n, ca_n;
	logic [1:0] op_q, op_n;
	logic [2:0] pleft_q, pleft_n;
	logic [2*PIX_W-1:0] prod_q;

	logic [5:0] run_left_q, run_left_n;
	logic run_last_q, run_last_n, pend_trunc_q, pend_trunc_n;
	item_t run_item_q, out_q, go_item, run_beat, trunc_beat;
	logic out_v_q, go_item_v;

	logic [31:0] mem [64];
	logic [31:0] rdat_q, fwd_dat_q, idx_e;
	logic [63:0] vld_q;
	logic vld_rd_q, fwd_q;
	logic mem_we, restart;
	logic [5:0] mem_wa;

	logic adv, run_busy, go, acc;
	logic [7:0] b, vg, ch, cs;
	logic emit, hdr_bad;
	logic [6:0] cnt, take;

	assign adv = !out_v_q || result.ready;
	assign run_busy = run_left_q != 6'd0;
	assign go = s1_v_q && !run_busy && !pend_trunc_q && adv;
	assign stream.ready = !s1_v_q || go;
	assign acc = stream.valid && stream.ready;
	assign cfg.ready = 1'b1;
	assign b = s1_byte_q;
	assign idx_e = fwd_q ? fwd_dat_q : (vld_rd_q ? rdat_q : 32'd0);

	always_comb begin
		phase_n = phase_q;
		hcnt_n = hcnt_q;
		hs_n = hs_q;
		wid_n = wid_q;
		hgt_n = hgt_q;
		four_n = four_q;
		pl_n = pl_q;
		cr_n = cr_q;
		cg_n = cg_q;
		cb_n = cb_q;
		ca_n = ca_q;
		op_n = op_q;
		pleft_n = pleft_q;
		pb_n = pb_q;
		run_left_n = 6'd0;
		run_last_n = 1'b0;
		pend_trunc_n = 1'b0;
		go_item = '0;
		go_item_v = 1'b0;
		emit = 1'b0;
		cnt = 7'd1;
		take = 7'd0;
		vg = 8'd0;
		ch = 8'd0;
		cs = 8'd0;
		hdr_bad = 1'b0;
		restart = s1_last_q;
		case (phase_q)
			PH_HEADER: begin
				hs_n = {hs_q[23:0], b};
				hcnt_n = hcnt_q + 4'd1;
				case (hcnt_n)
					HDR_MAGIC_END: begin
						if (hs_n != MAGIC_WORD) begin
							go_item_v = 1'b1;
							go_item.kind = KIND_BAD_MAGIC;
							go_item.last_item = 1'b1;
							phase_n = PH_IGNORE;
						end
					end
					HDR_WIDTH_END: wid_n = hs_n;
					HDR_HEIGHT_END: hgt_n = hs_n;
					HDR_END: begin
						ch = hs_n[15:8];
						cs = hs_n[7:0];
						hdr_bad = wid_q == 32'd0 || hgt_q == 32'd0 || ch < 8'd3 || ch > 8'd4
							|| cs > 8'd1 || wid_q > 32'(MAX_P) || hgt_q >= 32'(MAX_P)
							|| prod_q > (2*PIX_W)'(MAX_P);
						go_item_v = 1'b1;
						if (hdr_bad) begin
							go_item.kind = KIND_BAD_HEADER;
							go_item.last_item = 1'b1;
							phase_n = PH_IGNORE;
						end else begin
							case (mode_q)
								MODE_RGB: four_n = 1'b0;
								MODE_RGBA: four_n = 1'b1;
								default: four_n = ch == 8'd4;
							endcase
							pl_n = PIX_W'(prod_q - (2*PIX_W)'(wid_q[PIX_W-1:0]));
							go_item.kind = KIND_HEADER;
							go_item.alpha_valid = four_n;
							go_item.image_width = wid_q;
							go_item.image_height = hgt_q;
							go_item.header_channels = ch;
							go_item.color_space = cs;
							phase_n = PH_BODY;
						end
					end
					default: ;
				endcase
				if (s1_last_q && phase_n != PH_IGNORE) begin
					if (go_item_v) begin
						pend_trunc_n = 1'b1;
					end else begin
						go_item_v = 1'b1;
						go_item.kind = KIND_TRUNC;
						go_item.last_item = 1'b1;
					end
				end
			end
			PH_BODY: begin
				if (op_q != OP_NONE) begin
					pb_n = {pb_q[23:0], b};
					pleft_n = pleft_q - 3'd1;
					if (pleft_n == 3'd0) begin
						case (op_q)
							OP_RGB: begin
								cr_n = pb_n[23:16];
								cg_n = pb_n[15:8];
								cb_n = pb_n[7:0];
							end
							OP_RGBA: begin
								cr_n = pb_n[31:24];
								cg_n = pb_n[23:16];
								cb_n = pb_n[15:8];
								ca_n = pb_n[7:0];
							end
							default: begin
								vg = {2'b00, hs_q[5:0]} - 8'd32;
								cr_n = cr_q + vg - 8'd8 + {4'd0, b[7:4]};
								cg_n = cg_q + vg;
								cb_n = cb_q + vg - 8'd8 + {4'd0, b[3:0]};
							end
						endcase
						op_n = OP_NONE;
						pb_n = 32'd0;
						emit = 1'b1;
					end
				end else if (b == CHUNK_RGB) begin
					op_n = OP_RGB;
					pleft_n = 3'd3;
					pb_n = 32'd0;
				end else if (b == CHUNK_RGBA) begin
					op_n = OP_RGBA;
					pleft_n = 3'd4;
					pb_n = 32'd0;
				end else begin
					case (b[7:6])
						TAG_INDEX: begin
							{cr_n, cg_n, cb_n, ca_n} = idx_e;
							emit = 1'b1;
						end
						TAG_DIFF: begin
							cr_n = cr_q + {6'd0, b[5:4]} - 8'd2;
							cg_n = cg_q + {6'd0, b[3:2]} - 8'd2;
							cb_n = cb_q + {6'd0, b[1:0]} - 8'd2;
							emit = 1'b1;
						end
						TAG_LUMA: begin
							hs_n = {24'd0, b};
							op_n = OP_LUMA;
							pleft_n = 3'd1;
							pb_n = 32'd0;
						end
						default: begin
							cnt = {1'b0, b[5:0]} + 7'd1;
							emit = 1'b1;
						end
					endcase
				end
				if (emit) begin
					take = (pl_q < PIX_W'(cnt)) ? pl_q[6:0] : cnt;
					pl_n = pl_q - PIX_W'(take);
					if (pl_n == '0) phase_n = PH_IGNORE;
				end
				if (s1_last_q && pl_n != '0) begin
					go_item_v = 1'b1;
					go_item.kind = KIND_TRUNC;
					go_item.last_item = 1'b1;
				end else if (emit) begin
					go_item_v = 1'b1;
					go_item.kind = KIND_PIXEL;
					go_item.red = cr_n;
					go_item.green = cg_n;
					go_item.blue = cb_n;
					go_item.alpha = four_q ? ca_n : 8'd0;
					go_item.alpha_valid = four_q;
					go_item.last_item = take == 7'd1 && pl_n == '0;
					run_left_n = 6'(take - 7'd1);
					run_last_n = pl_n == '0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		run_beat = run_item_q;
		run_beat.last_item = run_left_q == 6'd1 && run_last_q;
		trunc_beat = '0;
		trunc_beat.kind = KIND_TRUNC;
		trunc_beat.last_item = 1'b1;
	end

	assign mem_we = go && emit;
	assign mem_wa = 6'(cr_n[5:0] * 6'd3 + cg_n[5:0] * 6'd5 + cb_n[5:0] * 6'd7 + ca_n[5:0] * 6'd11);

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= {cr_n, cg_n, cb_n, ca_n};
		if (acc) rdat_q <= mem[stream.data_byte[5:0]];
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s1_byte_q <= stream.data_byte;
			s1_last_q <= stream.stream_last;
			fwd_dat_q <= {cr_n, cg_n, cb_n, ca_n};
		end
		if (go && phase_q == PH_HEADER && hcnt_n == HDR_CH_BYTE)
			prod_q <= (hgt_q[PIX_W-1:0] + PIX_W'(1)) * wid_q[PIX_W-1:0];
		if (go && go_item_v) run_item_q <= go_item;
		if (adv) begin
			if (go && go_item_v) begin
				out_q <= go_item;
			end else if (run_busy) begin
				out_q <= run_beat;
			end else begin
				out_q <= trunc_beat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HDR;
			s1_v_q <= 1'b0;
			out_v_q <= 1'b0;
			run_left_q <= 6'd0;
			run_last_q <= 1'b0;
			pend_trunc_q <= 1'b0;
			vld_q <= '0;
			vld_rd_q <= 1'b0;
			fwd_q <= 1'b0;
			phase_q <= PH_HEADER;
			hcnt_q <= 4'd0;
			hs_q <= 32'd0;
			wid_q <= 32'd0;
			hgt_q <= 32'd0;
			four_q <= 1'b0;
			pl_q <= '0;
			{cr_q, cg_q, cb_q, ca_q} <= {24'd0, 8'd255};
			op_q <= OP_NONE;
			pleft_q <= 3'd0;
			pb_q <= 32'd0;
		end else begin
			if (cfg.valid) mode_q <= cfg.out_channels_mode;
			if (acc) begin
				s1_v_q <= 1'b1;
				vld_rd_q <= vld_q[stream.data_byte[5:0]];
				fwd_q <= mem_we && mem_wa == stream.data_byte[5:0];
			end else if (go) begin
				s1_v_q <= 1'b0;
			end
			if (adv) out_v_q <= (go && go_item_v) || run_busy || pend_trunc_q;
			if (adv && run_busy) run_left_q <= run_left_q - 6'd1;
			if (adv && pend_trunc_q) pend_trunc_q <= 1'b0;
			if (go) begin
				run_left_q <= run_left_n;
				run_last_q <= run_last_n;
				pend_trunc_q <= pend_trunc_n;
				if (restart) begin
					vld_q <= '0;
					phase_q <= PH_HEADER;
					hcnt_q <= 4'd0;
					hs_q <= 32'd0;
					wid_q <= 32'd0;
					hgt_q <= 32'd0;
					four_q <= 1'b0;
					pl_q <= '0;
					{cr_q, cg_q, cb_q, ca_q} <= {24'd0, 8'd255};
					op_q <= OP_NONE;
					pleft_q <= 3'd0;
					pb_q <= 32'd0;
				end else begin
					if (mem_we) vld_q[mem_wa] <= 1'b1;
					phase_q <= phase_n;
					hcnt_q <= hcnt_n;
					hs_q <= hs_n;
					wid_q <= wid_n;
					hgt_q <= hgt_n;
					four_q <= four_n;
					pl_q <= pl_n;
					{cr_q, cg_q, cb_q, ca_q} <= {cr_n, cg_n, cb_n, ca_n};
					op_q <= op_n;
					pleft_q <= pleft_n;
					pb_q <= pb_n;
				end
			end
		end
	end

	assign result.valid = out_v_q;
	assign result.item_kind = out_q.kind;
	assign result.red = out_q.red;
	assign result.green = out_q.green;
	assign result.blue = out_q.blue;
	assign result.alpha = out_q.alpha;
	assign result.alpha_valid = out_q.alpha_valid;
	assign result.last_item = out_q.last_item;
	assign result.image_width = out_q.image_width;
	assign result.image_height = out_q.image_height;
	assign result.header_channels = out_q.header_channels;
	assign result.color_space = out_q.color_space;

	a_run_trunc_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(run_busy && pend_trunc_q)) else $error("run and truncation beat both pending");
	a_run_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		run_busy |-> out_v_q) else $error("run pending with empty output register");
	a_trunc_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_trunc_q |-> out_v_q) else $error("truncation pending with empty output register");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		go && s1_last_q |=> phase_q == PH_HEADER && hcnt_q == 4'd0 && vld_q == '0)
		else $error("end of file did not restart the parser");

endmodule
